/* hw/rtl/track_sector_mark_scanner_defines.svh */
// Assertion macros used by the sector mark scanner top level.
`ifndef TRACK_SECTOR_MARK_SCANNER_DEFINES_SVH
`define TRACK_SECTOR_MARK_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside of reset.
`define TSMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsms assertion failed");

// Checks a property on every clock edge, reset included.
`define TSMS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tsms assertion failed");

`else

`define TSMS_ASSERT(lbl, clk, rst_n, prop)
`define TSMS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* hw/rtl/tsms_pkg.sv */
// Types and constants for the track sector mark scanner.
`default_nettype none

package tsms_pkg;

    localparam int MAX_SECTORS   = 64;
    localparam int LONGEST_TRACK = 6400;

    localparam int POS_W   = 13;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = $clog2(MAX_SECTORS + 1);
    localparam int SKIP_W  = 3;

    localparam logic [POS_W-1:0]  POS_MAX       = {POS_W{1'b1}};
    localparam logic [POS_W-1:0]  TRACK_LEN_MAX = POS_W'(LONGEST_TRACK);
    localparam logic [POS_W-1:0]  TRAILER_LEN   = POS_W'(8);
    localparam logic [POS_W-1:0]  FIELD_OFFSET  = POS_W'(2);
    localparam logic [POS_W-1:0]  TRACK_LEN_RST = POS_W'(6400);
    localparam logic [SKIP_W-1:0] SKIP_LEN      = SKIP_W'(7);
    localparam logic [COUNT_W-1:0] SECTOR_LIMIT = COUNT_W'(MAX_SECTORS);

    localparam logic [BYTE_W-1:0] SYNC_BYTE      = 8'hA1;
    localparam logic [BYTE_W-1:0] ID_MARK        = 8'hFE;
    localparam logic [BYTE_W-1:0] DATA_MARK      = 8'hFB;
    localparam logic [BYTE_W-1:0] DELETED_MARK   = 8'hF8;

    // Scan phase of the current track.
    typedef enum logic [1:0] {
        PH_SEEK_ID   = 2'd0,
        PH_SKIP      = 2'd1,
        PH_SEEK_DATA = 2'd2,
        PH_DONE      = 2'd3
    } phase_t;

    // One reported sector.
    typedef struct packed {
        logic [INDEX_W-1:0] sector_index;
        logic [POS_W-1:0]   id_pos;
        logic               data_found;
        logic [POS_W-1:0]   data_pos;
        logic               overflow;
    } sector_t;

endpackage

`default_nettype wire

/* hw/rtl/tsms_scan.sv */
// Scan state and per-byte sector decision logic.
`default_nettype none

module tsms_scan (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          beat_accept,
    input  wire logic [tsms_pkg::BYTE_W-1:0]   byte_value,
    input  wire logic                          mark_bit,
    input  wire logic                          track_start,
    input  wire logic [tsms_pkg::POS_W-1:0]    track_length,
    output logic                               res_valid,
    output tsms_pkg::sector_t                  res
);
    import tsms_pkg::*;

    logic [POS_W-1:0]   position_reg, position_next;
    logic [BYTE_W-1:0]  prev_byte_reg;
    logic               prev_mark_reg;
    phase_t             phase_reg, phase_next;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0]   held_reg, held_next;

    // State as seen by this beat, after an optional track start clear.
    logic [POS_W-1:0]   cur_pos;
    logic [BYTE_W-1:0]  cur_prev_byte;
    logic               cur_prev_mark;
    phase_t             cur_phase;
    logic [SKIP_W-1:0]  cur_skip;
    logic [COUNT_W-1:0] cur_count;
    logic [POS_W-1:0]   cur_held;

    logic [POS_W-1:0] tl_clamped;
    logic [POS_W-1:0] scan_len;
    logic [POS_W-1:0] p_dec;
    logic             active, in_range, at_end, prev_sync;
    logic             id_hit, data_hit, skip_step, end_emit, emit, found;
    phase_t           mid_phase;
    logic [POS_W-1:0] mid_held;

    assign cur_pos       = track_start ? '0 : position_reg;
    assign cur_prev_byte = track_start ? '0 : prev_byte_reg;
    assign cur_prev_mark = track_start ? 1'b0 : prev_mark_reg;
    assign cur_phase     = track_start ? PH_SEEK_ID : phase_reg;
    assign cur_skip      = track_start ? '0 : skip_reg;
    assign cur_count     = track_start ? '0 : count_reg;
    assign cur_held      = track_start ? '0 : held_reg;

    // Effective scan length: clamp the register, then drop the trailer.
    assign tl_clamped = (track_length > TRACK_LEN_MAX) ? TRACK_LEN_MAX : track_length;
    assign scan_len   = (tl_clamped > TRAILER_LEN) ? (tl_clamped - TRAILER_LEN) : '0;

    // Decisions concern the previous position, taken as this byte arrives.
    assign p_dec     = cur_pos - POS_W'(1);
    assign active    = (cur_pos != '0) && (cur_phase != PH_DONE);
    assign in_range  = active && (p_dec < scan_len);
    assign at_end    = active && (cur_pos >= scan_len);
    assign prev_sync = (cur_prev_byte == SYNC_BYTE) && cur_prev_mark;

    assign id_hit    = in_range && (cur_phase == PH_SEEK_ID) && prev_sync
                       && (byte_value == ID_MARK);
    assign skip_step = in_range && (cur_phase == PH_SKIP);
    assign data_hit  = in_range && (cur_phase == PH_SEEK_DATA) && prev_sync && !mark_bit;
    assign found     = data_hit && ((byte_value == DATA_MARK) || (byte_value == DELETED_MARK));

    // Phase after the position decision, before the end-of-scan check.
    always_comb begin
        mid_phase = cur_phase;
        mid_held  = cur_held;
        if (id_hit) begin
            mid_phase = PH_SKIP;
            mid_held  = p_dec + FIELD_OFFSET;
        end else if (skip_step && (cur_skip <= SKIP_W'(1))) begin
            mid_phase = PH_SEEK_DATA;
        end else if (data_hit) begin
            mid_phase = PH_SEEK_ID;
        end
    end

    assign end_emit = at_end && ((mid_phase == PH_SKIP) || (mid_phase == PH_SEEK_DATA));
    assign emit     = data_hit || end_emit;

    // Next state of the scan.
    always_comb begin
        phase_next = mid_phase;
        held_next  = mid_held;
        skip_next  = cur_skip;
        count_next = cur_count;
        if (id_hit) begin
            skip_next = SKIP_LEN;
        end else if (skip_step) begin
            skip_next = (cur_skip <= SKIP_W'(1)) ? '0 : (cur_skip - SKIP_W'(1));
        end
        if (at_end) begin
            phase_next = PH_DONE;
            skip_next  = '0;
        end
        if (emit && (cur_count < SECTOR_LIMIT)) begin
            count_next = cur_count + COUNT_W'(1);
        end
        position_next = (cur_pos < POS_MAX) ? (cur_pos + POS_W'(1)) : cur_pos;
    end

    // Result for this beat.
    always_comb begin
        res_valid        = beat_accept && emit;
        res.id_pos       = mid_held;
        res.data_found   = found;
        res.data_pos     = found ? (p_dec + FIELD_OFFSET) : '0;
        if (cur_count < SECTOR_LIMIT) begin
            res.sector_index = cur_count[INDEX_W-1:0];
            res.overflow     = 1'b0;
        end else begin
            res.sector_index = '0;
            res.overflow     = 1'b1;
        end
    end

    // State registers advance on every accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            prev_byte_reg <= '0;
            prev_mark_reg <= 1'b0;
            phase_reg     <= PH_SEEK_ID;
            skip_reg      <= '0;
            count_reg     <= '0;
            held_reg      <= '0;
        end else if (beat_accept) begin
            position_reg  <= position_next;
            prev_byte_reg <= byte_value;
            prev_mark_reg <= mark_bit;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/track_sector_mark_scanner.sv */
// Top level of the track sector mark scanner: config register and output buffer.
//
// Usage: track bytes enter on the s_ stream, one beat per byte position, with
// the byte in s_tdata and its sync mark bit and a track start flag in s_tuser.
// A beat with track start set is position 0 of a new track and clears the scan.
// Each sector found leaves as one beat on the m_ stream; most input beats
// produce none. The track length is written through cfg_wr_en/cfg_wr_data
// while the stream is idle; it resets to 6400.
// A sector decided by an input beat is registered in the output register, or in
// the skid register under a stall. Throughput: one input beat per cycle while
// s_tready is high, set by the single pass of compare logic between the scan state registers and the output register.
// When the receiver stalls, a second result is held in a skid register and
// s_tready drops only while both the output and skid registers are full.
// Reset (aresetn low, synchronous) empties both registers and returns the
// scan to seeking an ID mark at position 0; no memory needs clearing.
`default_nettype none

`include "track_sector_mark_scanner_defines.svh"

module track_sector_mark_scanner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic [1:0]  s_tuser,   // [0] mark_bit, [1] track_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [5:0] sector_index, [18:6] id_pos, [31:19] data_pos
    output logic [1:0]       m_tuser,   // [0] data_found, [1] overflow
    input  wire logic        cfg_wr_en,
    input  wire logic [12:0] cfg_wr_data
);
    import tsms_pkg::*;

    logic [POS_W-1:0] track_len_reg;
    logic             s_accept;
    logic             res_valid;
    sector_t          res;
    logic             out_valid_reg, out_valid_next;
    sector_t          out_reg, out_next;
    logic             skid_valid_reg, skid_valid_next;
    sector_t          skid_reg, skid_next;

    // Track length register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_len_reg <= TRACK_LEN_RST;
        end else if (cfg_wr_en) begin
            track_len_reg <= cfg_wr_data;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    tsms_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_accept  (s_accept),
        .byte_value   (s_tdata[7:0]),
        .mark_bit     (s_tuser[0]),
        .track_start  (s_tuser[1]),
        .track_length (track_len_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Output register with skid stage.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.data_pos, out_reg.id_pos, out_reg.sector_index};
    assign m_tuser  = {out_reg.overflow, out_reg.data_found};

    // The skid stage only fills behind a held output beat.
    `TSMS_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> out_valid_reg)
    // A result arriving under a stall must land in the skid stage.
    `TSMS_ASSERT(a_stall_to_skid, aclk, aresetn,
        (out_valid_reg && !m_tready && res_valid) |=> skid_valid_reg)
    // An overflowed sector carries index zero.
    `TSMS_ASSERT(a_ovf_index, aclk, aresetn,
        (out_valid_reg && out_reg.overflow) |-> (out_reg.sector_index == '0))
    // A sector without data reports data position zero.
    `TSMS_ASSERT(a_nodata_pos, aclk, aresetn,
        (out_valid_reg && !out_reg.data_found) |-> (out_reg.data_pos == '0))
    // Reset empties the output side.
    `TSMS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (!out_valid_reg && !skid_valid_reg))

endmodule

`default_nettype wire

/* test/tb_track_sector_mark_scanner.sv */
// Self-checking testbench for the track sector mark scanner, with its sector scoreboard.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the scan state and predicts each sector beat.
class sector_scoreboard;
    logic [12:0]           track_len;
    logic [12:0]           pos;
    logic [7:0]            last_byte;
    logic                  last_mark;
    tsms_pkg::phase_t      scan_phase;
    logic [2:0]            skip_left;
    logic [6:0]            found_count;
    logic [12:0]           id_field_pos;
    tsms_pkg::sector_t     sectors_due[$];
    int                    errors;
    int                    checked;
    int                    with_data;
    int                    overflowed;
    int                    scanned;

    function new();
        track_len  = tsms_pkg::TRACK_LEN_RST;
        errors     = 0;
        checked    = 0;
        with_data  = 0;
        overflowed = 0;
        scanned    = 0;
        clear_scan();
    endfunction

    function void clear_scan();
        pos          = '0;
        last_byte    = '0;
        last_mark    = 1'b0;
        scan_phase   = tsms_pkg::PH_SEEK_ID;
        skip_left    = '0;
        found_count  = '0;
        id_field_pos = '0;
    endfunction

    // Queues one sector; once the table is full it is reported as overflow with index 0.
    function void queue_sector(bit found, logic [12:0] dpos);
        tsms_pkg::sector_t s;
        s.id_pos     = id_field_pos;
        s.data_found = found;
        s.data_pos   = found ? dpos : '0;
        if (found_count < tsms_pkg::MAX_SECTORS) begin
            s.sector_index = found_count[5:0];
            s.overflow     = 1'b0;
            found_count++;
        end else begin
            s.sector_index = '0;
            s.overflow     = 1'b1;
        end
        sectors_due.push_back(s);
    endfunction

    // Notes one accepted track byte. The decision for the previous position is taken now.
    function void note_beat(logic [7:0] b, bit m, bit start);
        logic [12:0] eff_len;
        logic [12:0] scan_len;
        logic [12:0] p;
        if (start || scan_phase != tsms_pkg::PH_DONE)
            scanned++;
        if (start)
            clear_scan();
        eff_len  = (track_len > tsms_pkg::TRACK_LEN_MAX) ? tsms_pkg::TRACK_LEN_MAX : track_len;
        scan_len = (eff_len > tsms_pkg::TRAILER_LEN) ? eff_len - tsms_pkg::TRAILER_LEN : '0;
        if (pos != '0 && scan_phase != tsms_pkg::PH_DONE) begin
            p = pos - 13'd1;
            if (p < scan_len) begin
                case (scan_phase)
                    tsms_pkg::PH_SEEK_ID: begin
                        if (last_byte == tsms_pkg::SYNC_BYTE && last_mark
                                && b == tsms_pkg::ID_MARK) begin
                            id_field_pos = p + tsms_pkg::FIELD_OFFSET;
                            scan_phase   = tsms_pkg::PH_SKIP;
                            skip_left    = tsms_pkg::SKIP_LEN;
                        end
                    end
                    tsms_pkg::PH_SKIP: begin
                        if (skip_left <= 3'd1) begin
                            skip_left  = '0;
                            scan_phase = tsms_pkg::PH_SEEK_DATA;
                        end else begin
                            skip_left--;
                        end
                    end
                    default: begin
                        // A marked sync followed by an unmarked byte closes the sector.
                        if (last_byte == tsms_pkg::SYNC_BYTE && last_mark && !m) begin
                            queue_sector(b == tsms_pkg::DATA_MARK || b == tsms_pkg::DELETED_MARK,
                                         p + tsms_pkg::FIELD_OFFSET);
                            scan_phase = tsms_pkg::PH_SEEK_ID;
                        end
                    end
                endcase
            end
            // End of the scanned area: a sector still in progress leaves without data.
            if (pos >= scan_len) begin
                if (scan_phase == tsms_pkg::PH_SKIP || scan_phase == tsms_pkg::PH_SEEK_DATA)
                    queue_sector(1'b0, '0);
                scan_phase = tsms_pkg::PH_DONE;
                skip_left  = '0;
            end
        end
        last_byte = b;
        last_mark = m;
        if (pos != tsms_pkg::POS_MAX)
            pos++;
    endfunction

    function void compare_field(string name, logic [12:0] want, logic [12:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Checks one accepted sector beat against the oldest prediction.
    function void check_result(logic [31:0] tdata, logic [1:0] tuser);
        tsms_pkg::sector_t want;
        if (sectors_due.size() == 0) begin
            $display("%0t: sector beat with none expected, expected nothing, actual tdata %h tuser %b",
                     $time, tdata, tuser);
            errors++;
            return;
        end
        want = sectors_due.pop_front();
        checked++;
        compare_field("sector_index", 13'(want.sector_index), 13'(tdata[5:0]));
        compare_field("id_pos", want.id_pos, tdata[18:6]);
        compare_field("data_pos", want.data_pos, tdata[31:19]);
        compare_field("data_found", 13'(want.data_found), 13'(tuser[0]));
        compare_field("overflow", 13'(want.overflow), 13'(tuser[1]));
        if (want.data_found)
            with_data++;
        if (want.overflow)
            overflowed++;
    endfunction
endclass

module tb_track_sector_mark_scanner;
    import tsms_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int IDLE_PCT     = 21;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 4;
    localparam int TARGET_BEATS = 1250;

    localparam int STYLE_CLEAN = 0;
    localparam int STYLE_NOISY = 1;
    localparam int STYLE_DENSE = 2;

    typedef struct packed {
        logic [7:0] value;
        logic       mark;
    } track_byte_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en   = 1'b0;
    logic [12:0] cfg_wr_data = '0;

    sector_scoreboard sb = new();
    track_byte_t      layout[$];
    logic             calm         = 1'b0;
    int               beats        = 0;
    int               tracks_sent  = 0;
    int               settings     = 0;
    int               quiet_cycles = 0;

    track_sector_mark_scanner uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Receiver: checks each sector beat and stalls at random outside the calm stretch.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Sends one track byte, with random idle cycles before it.
    task automatic send_beat(input logic [7:0] b, input bit m, input bit start);
        calm <= (beats >= 150 && beats < 400);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {start, m};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_beat(b, m, start);
        beats++;
    endtask

    // Lets every predicted sector arrive and the block settle before a register write.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.sectors_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_track_length(input logic [12:0] len);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        sb.track_len = len;
        settings++;
    endtask

    function automatic void add(input logic [7:0] v, input bit m);
        layout.push_back('{value: v, mark: m});
    endfunction

    // One sector as a controller writes it: syncs, ID mark, ID field, gap, syncs, data mark.
    function automatic void add_sector(input bit dense);
        int n;
        int pick;
        n = dense ? 1 : $urandom_range(1, 3);
        repeat (n) add(SYNC_BYTE, 1'b1);
        add(ID_MARK, 1'b0);
        repeat (6) add(8'($urandom), 1'b0);
        if (!dense)
            repeat ($urandom_range(0, 3)) add(8'($urandom), 1'b0);
        // Now and then the data mark is missing, so the next ID sync gets taken for it.
        if (!dense && $urandom_range(0, 9) == 0)
            return;
        n = dense ? 1 : $urandom_range(1, 3);
        repeat (n) add(SYNC_BYTE, 1'b1);
        pick = $urandom_range(0, 9);
        add(pick < 4 ? DATA_MARK : (pick < 7 ? DELETED_MARK : 8'($urandom)), 1'b0);
        if (!dense)
            repeat ($urandom_range(0, 6)) add(8'($urandom), 1'b0);
    endfunction

    // Noise leans toward the interesting byte values and sets the mark bit often.
    function automatic void add_noise(input int n);
        int         pick;
        logic [7:0] v;
        repeat (n) begin
            pick = $urandom_range(0, 9);
            v = (pick < 3) ? SYNC_BYTE : (pick == 3) ? ID_MARK :
                (pick == 4) ? DATA_MARK : 8'($urandom);
            add(v, $urandom_range(0, 3) == 0);
        end
    endfunction

    function automatic void build_track(input int target, input int style);
        layout.delete();
        while (layout.size() < target) begin
            if (style == STYLE_DENSE)
                add_sector(1'b1);
            else if (style == STYLE_NOISY || $urandom_range(0, 4) == 0)
                add_noise($urandom_range(1, 6));
            else
                add_sector(1'b0);
        end
        while (layout.size() > target)
            void'(layout.pop_back());
    endfunction

    // Sends the built track; a rare stray track start breaks it up.
    task automatic send_layout(input bit with_start);
        int i;
        for (i = 0; i < layout.size(); i++)
            send_beat(layout[i].value, layout[i].mark,
                      (with_start && i == 0) || $urandom_range(0, 299) == 0);
    endtask

    // One setting of the track length followed by a few tracks.
    task automatic run_phase(input logic [12:0] len, input int tracks, input int style);
        int eff;
        int t;
        int target;
        wait_drained();
        write_track_length(len);
        eff = (len > LONGEST_TRACK) ? LONGEST_TRACK : len;
        for (t = 0; t < tracks; t++) begin
            if (style == STYLE_DENSE)
                target = eff;
            else if (eff > 300)
                target = $urandom_range(60, 200);
            else if (eff <= 8)
                target = $urandom_range(4, 16);
            else
                target = eff + $urandom_range(0, 3);
            build_track(target, style);
            // The first track sometimes carries on the scan left over from the last setting.
            send_layout(t > 0 || style == STYLE_DENSE || $urandom_range(0, 3) != 0);
            tracks_sent++;
        end
    endtask

    initial begin
        int          pick;
        logic [12:0] len;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed track: a deleted-data sector behind a sync run with mark bits in the skip,
        // a sector whose data mark is some other byte, and an ID mark so close to the end
        // that the scan closes while still skipping.
        write_track_length(13'd32);
        layout.delete();
        add(SYNC_BYTE, 1'b1);
        add(ID_MARK, 1'b0);
        add(8'h00, 1'b0);
        add(8'hFF, 1'b0);
        add(8'h00, 1'b1);
        add(8'hFF, 1'b1);
        add(8'h00, 1'b0);
        add(8'hFF, 1'b0);
        add(SYNC_BYTE, 1'b1);
        add(SYNC_BYTE, 1'b1);
        add(DELETED_MARK, 1'b0);
        add(SYNC_BYTE, 1'b1);
        add(ID_MARK, 1'b0);
        repeat (6) add(8'h5A, 1'b0);
        add(SYNC_BYTE, 1'b1);
        add(8'h3C, 1'b0);
        add(SYNC_BYTE, 1'b1);
        add(ID_MARK, 1'b0);
        add(8'hAA, 1'b0);
        add(8'h55, 1'b0);
        send_layout(1'b1);
        tracks_sent++;

        // Fixed settings first: a full sector table, the reset length, a length above the
        // limit, a length of 16 and an empty scan.
        run_phase(13'd680, 1, STYLE_DENSE);
        run_phase(TRACK_LEN_RST, 2, STYLE_CLEAN);
        run_phase(POS_MAX, 2, STYLE_CLEAN);
        run_phase(13'd16, 2, STYLE_CLEAN);
        run_phase(13'd0, 1, STYLE_NOISY);

        while (sb.scanned < TARGET_BEATS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       len = TRACK_LEN_RST;
                1:       len = 13'($urandom_range(LONGEST_TRACK + 1, 8191));
                2:       len = 13'($urandom_range(0, 8));
                3:       len = 13'($urandom_range(9, 16));
                default: len = 13'($urandom_range(17, 160));
            endcase
            run_phase(len, $urandom_range(1, 3),
                      ($urandom_range(0, 6) == 0) ? STYLE_NOISY : STYLE_CLEAN);
        end
        wait_drained();

        $display("Run covered %0d beats (%0d scanned) in %0d tracks under %0d length settings.",
                 beats, sb.scanned, tracks_sent, settings);
        $display("Sectors checked: %0d, %0d with a data mark, %0d past a full table.",
                 sb.checked, sb.with_data, sb.overflowed);
        if (sb.errors == 0 && sb.sectors_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tsms_pkg.sv
hw/rtl/tsms_scan.sv
hw/rtl/track_sector_mark_scanner.sv
test/tb_track_sector_mark_scanner.sv
